// File: src/ffcl_pkg.sv
// Shared types and constants for the flood-fill component labeler.
package ffcl_pkg;

	localparam int LABEL_W = 8;
	localparam int CFG_W   = 5;

	localparam logic       CMD_LOAD = 1'b0;
	localparam logic       CMD_READ = 1'b1;
	localparam logic       REG_ROWS = 1'b0;
	localparam logic       REG_COLS = 1'b1;

	localparam logic [LABEL_W-1:0] LABEL_MAX = 8'hFF;

	localparam logic [CFG_W-1:0] ROWS_RST = 5'd10;
	localparam logic [CFG_W-1:0] COLS_RST = 5'd10;

	typedef enum logic [2:0] {
		STEP_HERE,
		STEP_RIGHT,
		STEP_DOWN,
		STEP_LEFT,
		STEP_UP
	} step_t;

	typedef enum logic [1:0] {
		T_IDLE,
		T_READ,
		T_PASS
	} top_state_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLEAR,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_NEXT,
		S_POP,
		S_POP_WAIT,
		S_NB_RD,
		S_NB_CHK
	} seq_state_t;

	// requests from the item handler to the sequencer
	typedef struct packed {
		logic load_we;
		logic land;
		logic rd_en;
		logic start;
	} ffcl_host_t;

	// sequencer status back to the item handler
	typedef struct packed {
		logic               finish;
		logic [LABEL_W-1:0] count;
	} ffcl_stat_t;

	// neighbour order: right, down, left, up
	function automatic step_t nbr_step(input logic [1:0] k);
		step_t s;
		case (k)
			2'd0:    s = STEP_RIGHT;
			2'd1:    s = STEP_DOWN;
			2'd2:    s = STEP_LEFT;
			default: s = STEP_UP;
		endcase
		return s;
	endfunction

endpackage

// File: src/flood_fill_component_labeler_top.sv
// Loads and reads take one item each: a load answers in the cycle after it is taken, a read once
// the registered label memory read and then the output register have passed it.
// A load with last set runs a labeling pass of label clearing over all MAX_ROWS*MAX_COLS cells,
// then a read, a check and an advance per scanned cell plus, for each land cell, a queue pop and
// a read per neighbour on the shared step unit, with a check where the neighbour lies in the grid,
// and one closing pop per component; the next item is taken once the result is out.
// Reset: control clears, grid size 10 by 10, count 0, done 0; labels read 0 until the first pass.
module flood_fill_component_labeler_top #(
	parameter int MAX_ROWS = 16,
	parameter int MAX_COLS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               cmd,
	input  logic [7:0]                         cell_index,
	input  logic [7:0]                         cell_value,
	input  logic                               last,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [ffcl_pkg::LABEL_W-1:0]       label,
	output logic [ffcl_pkg::LABEL_W-1:0]       component_count,
	output logic                               done_res,
	input  logic                               cfg_we,
	input  logic                               cfg_addr,
	input  logic [ffcl_pkg::CFG_W-1:0]         cfg_wdata
);

	localparam int RW     = $clog2(MAX_ROWS);
	localparam int CW     = $clog2(MAX_COLS);
	localparam int NCELLS = MAX_ROWS * MAX_COLS;
	localparam int AW     = $clog2(NCELLS);
	localparam int XW     = ((AW > 8) ? AW : 8) + 1;

	ffcl_pkg::top_state_t state_q, state_d;

	logic [ffcl_pkg::CFG_W-1:0]   grid_rows_q, grid_cols_q;
	logic [RW-1:0]                rows_last;
	logic [CW-1:0]                cols_last;
	logic                         done_flag_q, pass_seen_q, in_range_q;
	logic                         out_valid_q, out_done_q;
	logic [ffcl_pkg::LABEL_W-1:0] out_label_q, out_count_q;

	logic                         accept, in_range, emit;
	logic [XW-1:0]                idx_x;
	logic [ffcl_pkg::LABEL_W-1:0] rd_label, emit_label;
	logic                         emit_done;
	ffcl_pkg::ffcl_host_t         host;
	ffcl_pkg::ffcl_stat_t         stat;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows_q <= ffcl_pkg::ROWS_RST;
			grid_cols_q <= ffcl_pkg::COLS_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				ffcl_pkg::REG_ROWS: grid_rows_q <= cfg_wdata;
				ffcl_pkg::REG_COLS: grid_cols_q <= cfg_wdata;
				default:            grid_rows_q <= grid_rows_q;
			endcase
		end
	end

	// clamp grid size to 1..MAX and turn it into the last row/column index
	always_comb begin
		if (grid_rows_q == '0) begin
			rows_last = '0;
		end else if (32'(grid_rows_q) > MAX_ROWS) begin
			rows_last = RW'(MAX_ROWS - 1);
		end else begin
			rows_last = RW'(grid_rows_q - ffcl_pkg::CFG_W'(1));
		end
		if (grid_cols_q == '0) begin
			cols_last = '0;
		end else if (32'(grid_cols_q) > MAX_COLS) begin
			cols_last = CW'(MAX_COLS - 1);
		end else begin
			cols_last = CW'(grid_cols_q - ffcl_pkg::CFG_W'(1));
		end
	end

	assign idx_x    = XW'(cell_index);
	assign in_range = (idx_x < XW'(NCELLS));
	assign in_ready = (state_q == ffcl_pkg::T_IDLE) && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;

	// item handler: next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ffcl_pkg::T_IDLE: begin
				if (accept && cmd == ffcl_pkg::CMD_READ) begin
					state_d = ffcl_pkg::T_READ;
				end else if (accept && last) begin
					state_d = ffcl_pkg::T_PASS;
				end
			end
			ffcl_pkg::T_READ: state_d = ffcl_pkg::T_IDLE;
			ffcl_pkg::T_PASS: if (stat.finish) state_d = ffcl_pkg::T_IDLE;
			default:          state_d = ffcl_pkg::T_IDLE;
		endcase
	end

	// item handler: outputs
	always_comb begin
		host.load_we = 1'b0;
		host.land    = (cell_value != '0);
		host.rd_en   = 1'b0;
		host.start   = 1'b0;
		emit         = 1'b0;
		emit_label   = '0;
		emit_done    = done_flag_q;
		unique case (state_q)
			ffcl_pkg::T_IDLE: begin
				if (accept && cmd == ffcl_pkg::CMD_READ) begin
					host.rd_en = 1'b1;
				end else if (accept) begin
					host.load_we = in_range;
					host.start   = last;
					emit         = !last;
					emit_done    = 1'b0;
				end
			end
			ffcl_pkg::T_READ: begin
				emit       = 1'b1;
				emit_label = (in_range_q && pass_seen_q) ? rd_label : '0;
			end
			ffcl_pkg::T_PASS: begin
				emit      = stat.finish;
				emit_done = 1'b1;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ffcl_pkg::T_IDLE;
			done_flag_q <= 1'b0;
			pass_seen_q <= 1'b0;
			in_range_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) in_range_q <= in_range;
			if (accept && cmd == ffcl_pkg::CMD_LOAD) done_flag_q <= 1'b0;
			if (state_q == ffcl_pkg::T_PASS && stat.finish) begin
				done_flag_q <= 1'b1;
				pass_seen_q <= 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_label_q <= emit_label;
			out_count_q <= stat.count;
			out_done_q  <= emit_done;
		end
	end

	ffcl_seq #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.host      (host),
		.host_addr (idx_x[AW-1:0]),
		.rows_last (rows_last),
		.cols_last (cols_last),
		.rd_label  (rd_label),
		.stat      (stat)
	);

	assign out_valid       = out_valid_q;
	assign label           = out_label_q;
	assign component_count = out_count_q;
	assign done_res        = out_done_q;

endmodule

// File: src/ffcl_ram.sv
// Simple dual-port RAM: one write port, one registered read port.
module ffcl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: src/ffcl_nbr.sv
// Shared step unit: neighbour coordinates, grid-edge check and cell address.
module ffcl_nbr #(
	parameter int MAX_ROWS = 16,
	parameter int MAX_COLS = 16
) (
	input  ffcl_pkg::step_t                            step,
	input  logic [$clog2(MAX_ROWS)-1:0]                r,
	input  logic [$clog2(MAX_COLS)-1:0]                c,
	input  logic [$clog2(MAX_ROWS)-1:0]                rows_last,
	input  logic [$clog2(MAX_COLS)-1:0]                cols_last,
	output logic                                       ok,
	output logic [$clog2(MAX_ROWS)-1:0]                nr,
	output logic [$clog2(MAX_COLS)-1:0]                nc,
	output logic [$clog2(MAX_ROWS*MAX_COLS)-1:0]       addr
);

	localparam int RW = $clog2(MAX_ROWS);
	localparam int CW = $clog2(MAX_COLS);
	localparam int AW = $clog2(MAX_ROWS * MAX_COLS);

	always_comb begin
		ok = 1'b1;
		nr = r;
		nc = c;
		unique case (step)
			ffcl_pkg::STEP_HERE: begin
				ok = 1'b1;
			end
			ffcl_pkg::STEP_RIGHT: begin
				ok = (c != cols_last);
				nc = c + CW'(1);
			end
			ffcl_pkg::STEP_DOWN: begin
				ok = (r != rows_last);
				nr = r + RW'(1);
			end
			ffcl_pkg::STEP_LEFT: begin
				ok = (c != '0);
				nc = c - CW'(1);
			end
			ffcl_pkg::STEP_UP: begin
				ok = (r != '0);
				nr = r - RW'(1);
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

	assign addr = AW'(nr) * AW'(MAX_COLS) + AW'(nc);

endmodule

// File: src/ffcl_seq.sv
// Labeling sequencer: label clear sweep, raster scan and breadth-first fill.
module ffcl_seq #(
	parameter int MAX_ROWS = 16,
	parameter int MAX_COLS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  ffcl_pkg::ffcl_host_t                  host,
	input  logic [$clog2(MAX_ROWS*MAX_COLS)-1:0]  host_addr,
	input  logic [$clog2(MAX_ROWS)-1:0]           rows_last,
	input  logic [$clog2(MAX_COLS)-1:0]           cols_last,
	output logic [ffcl_pkg::LABEL_W-1:0]          rd_label,
	output ffcl_pkg::ffcl_stat_t                  stat
);

	localparam int RW     = $clog2(MAX_ROWS);
	localparam int CW     = $clog2(MAX_COLS);
	localparam int NCELLS = MAX_ROWS * MAX_COLS;
	localparam int AW     = $clog2(NCELLS);
	localparam int QW     = RW + CW;

	ffcl_pkg::seq_state_t state_q, state_d;

	logic [RW-1:0]                r_q, cr_q;
	logic [CW-1:0]                c_q, cc_q;
	logic [1:0]                   k_q;
	logic [AW:0]                  head_q, tail_q;
	logic [AW-1:0]                clr_q, wr_addr_q;
	logic [QW-1:0]                nb_rc_q;
	logic [ffcl_pkg::LABEL_W-1:0] count_q, count_inc;

	// step unit
	ffcl_pkg::step_t step;
	logic [RW-1:0]   u_r, u_nr;
	logic [CW-1:0]   u_c, u_nc;
	logic            u_ok;
	logic [AW-1:0]   u_addr;

	// memory ports
	logic                         land_we, land_re, land_rd;
	logic                         lab_we, lab_re;
	logic [AW-1:0]                lab_waddr, mem_raddr;
	logic [ffcl_pkg::LABEL_W-1:0] lab_wdata, lab_rd;
	logic                         q_we, q_re;
	logic [AW-1:0]                q_waddr;
	logic [QW-1:0]                q_wdata, q_rd;

	logic fresh, k_end, in_tail;

	ffcl_nbr #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_nbr (
		.step      (step),
		.r         (u_r),
		.c         (u_c),
		.rows_last (rows_last),
		.cols_last (cols_last),
		.ok        (u_ok),
		.nr        (u_nr),
		.nc        (u_nc),
		.addr      (u_addr)
	);

	ffcl_ram #(.WIDTH(1), .DEPTH(NCELLS)) u_land (
		.clk   (clk),
		.we    (land_we),
		.waddr (host_addr),
		.wdata (host.land),
		.re    (land_re),
		.raddr (mem_raddr),
		.rdata (land_rd)
	);

	ffcl_ram #(.WIDTH(ffcl_pkg::LABEL_W), .DEPTH(NCELLS)) u_label (
		.clk   (clk),
		.we    (lab_we),
		.waddr (lab_waddr),
		.wdata (lab_wdata),
		.re    (lab_re),
		.raddr (mem_raddr),
		.rdata (lab_rd)
	);

	ffcl_ram #(.WIDTH(QW), .DEPTH(NCELLS)) u_queue (
		.clk   (clk),
		.we    (q_we),
		.waddr (q_waddr),
		.wdata (q_wdata),
		.re    (q_re),
		.raddr (head_q[AW-1:0]),
		.rdata (q_rd)
	);

	// unvisited land: labels are cleared at pass start and never zero once set
	assign fresh     = land_rd && (lab_rd == '0);
	assign count_inc = (count_q == ffcl_pkg::LABEL_MAX) ? count_q
		: count_q + ffcl_pkg::LABEL_W'(1);
	assign k_end     = (k_q == 2'd3);
	assign in_tail   = (tail_q < (AW+1)'(NCELLS));

	// outputs of the sequencer
	always_comb begin
		step      = ffcl_pkg::STEP_HERE;
		u_r       = r_q;
		u_c       = c_q;
		land_we   = 1'b0;
		land_re   = 1'b0;
		lab_we    = 1'b0;
		lab_re    = 1'b0;
		lab_waddr = wr_addr_q;
		lab_wdata = count_q;
		mem_raddr = u_addr;
		q_we      = 1'b0;
		q_re      = 1'b0;
		q_waddr   = tail_q[AW-1:0];
		q_wdata   = nb_rc_q;
		unique case (state_q)
			ffcl_pkg::S_IDLE: begin
				mem_raddr = host_addr;
				land_we   = host.load_we;
				lab_re    = host.rd_en;
			end
			ffcl_pkg::S_CLEAR: begin
				lab_we    = 1'b1;
				lab_waddr = clr_q;
				lab_wdata = '0;
			end
			ffcl_pkg::S_SCAN_RD: begin
				land_re = 1'b1;
				lab_re  = 1'b1;
			end
			ffcl_pkg::S_SCAN_CHK: begin
				lab_we    = fresh;
				lab_wdata = count_inc;
				q_we      = fresh;
				q_waddr   = '0;
				q_wdata   = {r_q, c_q};
			end
			ffcl_pkg::S_POP: begin
				q_re = (head_q != tail_q);
			end
			ffcl_pkg::S_NB_RD: begin
				step    = ffcl_pkg::nbr_step(k_q);
				u_r     = cr_q;
				u_c     = cc_q;
				land_re = u_ok;
				lab_re  = u_ok;
			end
			ffcl_pkg::S_NB_CHK: begin
				lab_we = fresh && in_tail;
				q_we   = fresh && in_tail;
			end
			default: begin
				step = ffcl_pkg::STEP_HERE;
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ffcl_pkg::S_IDLE:     if (host.start) state_d = ffcl_pkg::S_CLEAR;
			ffcl_pkg::S_CLEAR:    if (clr_q == AW'(NCELLS - 1)) state_d = ffcl_pkg::S_SCAN_RD;
			ffcl_pkg::S_SCAN_RD:  state_d = ffcl_pkg::S_SCAN_CHK;
			ffcl_pkg::S_SCAN_CHK: state_d = fresh ? ffcl_pkg::S_POP : ffcl_pkg::S_NEXT;
			ffcl_pkg::S_NEXT: begin
				if (c_q == cols_last && r_q == rows_last) begin
					state_d = ffcl_pkg::S_IDLE;
				end else begin
					state_d = ffcl_pkg::S_SCAN_RD;
				end
			end
			ffcl_pkg::S_POP: begin
				state_d = (head_q == tail_q) ? ffcl_pkg::S_NEXT : ffcl_pkg::S_POP_WAIT;
			end
			ffcl_pkg::S_POP_WAIT: state_d = ffcl_pkg::S_NB_RD;
			ffcl_pkg::S_NB_RD: begin
				if (u_ok) begin
					state_d = ffcl_pkg::S_NB_CHK;
				end else if (k_end) begin
					state_d = ffcl_pkg::S_POP;
				end
			end
			ffcl_pkg::S_NB_CHK: state_d = k_end ? ffcl_pkg::S_POP : ffcl_pkg::S_NB_RD;
			default: state_d = ffcl_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ffcl_pkg::S_IDLE;
			r_q       <= '0;
			c_q       <= '0;
			cr_q      <= '0;
			cc_q      <= '0;
			k_q       <= '0;
			head_q    <= '0;
			tail_q    <= '0;
			clr_q     <= '0;
			wr_addr_q <= '0;
			nb_rc_q   <= '0;
			count_q   <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ffcl_pkg::S_IDLE: begin
					if (host.start) begin
						clr_q   <= '0;
						count_q <= '0;
						r_q     <= '0;
						c_q     <= '0;
					end
				end
				ffcl_pkg::S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
				end
				ffcl_pkg::S_SCAN_RD: begin
					wr_addr_q <= u_addr;
				end
				ffcl_pkg::S_SCAN_CHK: begin
					if (fresh) begin
						count_q <= count_inc;
						head_q  <= '0;
						tail_q  <= (AW+1)'(1);
					end
				end
				ffcl_pkg::S_NEXT: begin
					if (c_q == cols_last) begin
						c_q <= '0;
						r_q <= r_q + RW'(1);
					end else begin
						c_q <= c_q + CW'(1);
					end
				end
				ffcl_pkg::S_POP: begin
					k_q <= '0;
				end
				ffcl_pkg::S_POP_WAIT: begin
					{cr_q, cc_q} <= q_rd;
				end
				ffcl_pkg::S_NB_RD: begin
					wr_addr_q <= u_addr;
					nb_rc_q   <= {u_nr, u_nc};
					if (!u_ok) begin
						k_q <= k_q + 2'd1;
						if (k_end) head_q <= head_q + (AW+1)'(1);
					end
				end
				ffcl_pkg::S_NB_CHK: begin
					if (fresh && in_tail) tail_q <= tail_q + (AW+1)'(1);
					k_q <= k_q + 2'd1;
					if (k_end) head_q <= head_q + (AW+1)'(1);
				end
				default: begin
					k_q <= k_q;
				end
			endcase
		end
	end

	assign rd_label     = lab_rd;
	assign stat.finish  = (state_q == ffcl_pkg::S_NEXT) && (state_d == ffcl_pkg::S_IDLE);
	assign stat.count   = count_q;

endmodule
